@@ src/ghn_pkg.sv @@
// ----------------------------------------------------------------------------
// ghn_pkg: shared types and constants of the gray histogram normalizer
// operation codes, command kinds, queue sizing and back-end states
// ----------------------------------------------------------------------------
package ghn_pkg;

    localparam int NUM_BINS_DEF    = 256;
    localparam int COUNT_WIDTH_DEF = 24;

    localparam int OP_W     = 2;
    localparam int PIX_W    = 8;
    localparam int HEIGHT_W = 10;
    localparam int STEP_W   = $clog2(HEIGHT_W);

    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(400);

    // command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_COUNT = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    typedef enum logic [1:0] {
        K_CLEAR,
        K_COUNT,
        K_READ,
        K_NOP
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [PIX_W-1:0]  idx;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DIVIDE,
        ST_HOLD
    } state_t;

endpackage

@@ src/ghn_if.sv @@
// ----------------------------------------------------------------------------
// ghn_if: item channels of the gray histogram normalizer
// request channel (operation and operands) and result channel
// ----------------------------------------------------------------------------
interface ghn_in_if;
    import ghn_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [PIX_W-1:0] pixel_value;
    logic [PIX_W-1:0] bin_index;

    modport source (output valid, operation, pixel_value, bin_index, input ready);
    modport sink   (input valid, operation, pixel_value, bin_index, output ready);
endinterface

interface ghn_out_if #(
    parameter int COUNT_WIDTH = ghn_pkg::COUNT_WIDTH_DEF
);
    import ghn_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [HEIGHT_W-1:0]    scaled_height;
    logic [COUNT_WIDTH-1:0] raw_count;
    logic [COUNT_WIDTH-1:0] max_count;

    modport source (output valid, scaled_height, raw_count, max_count, input ready);
    modport sink   (input valid, scaled_height, raw_count, max_count, output ready);
endinterface

@@ src/ghn_front.sv @@
// ----------------------------------------------------------------------------
// ghn_front: request intake
// decodes each item into a command and holds it in a short queue
// ----------------------------------------------------------------------------
module ghn_front #(
    parameter int NUM_BINS = ghn_pkg::NUM_BINS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    ghn_in_if.sink        request,
    output logic          cmd_valid,
    output ghn_pkg::cmd_t cmd,
    input  logic          cmd_take
);
    import ghn_pkg::*;

    localparam logic [PIX_W:0] BIN_LIMIT = (PIX_W + 1)'(NUM_BINS);

    cmd_t              new_cmd;
    cmd_t              q_mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    logic              push;
    logic              pop;

    // classify: unused codes and out-of-range pixels and bins become no-ops
    always_comb
    begin
        new_cmd.idx  = request.pixel_value;
        new_cmd.kind = K_NOP;
        case (request.operation)
            OP_CLEAR:
            begin
                new_cmd.kind = K_CLEAR;
            end
            OP_COUNT:
            begin
                new_cmd.idx = request.pixel_value;
                if ({1'b0, request.pixel_value} < BIN_LIMIT)
                    new_cmd.kind = K_COUNT;
            end
            OP_READ:
            begin
                new_cmd.idx = request.bin_index;
                if ({1'b0, request.bin_index} < BIN_LIMIT)
                    new_cmd.kind = K_READ;
            end
            default:
            begin
                new_cmd.kind = K_NOP;
            end
        endcase
    end

    assign request.ready = (fill_reg != QCNT_W'(QDEPTH));
    assign push          = request.valid && request.ready;
    assign cmd_valid     = (fill_reg != '0);
    assign pop           = cmd_take && cmd_valid;
    assign cmd           = q_mem[rd_ptr_reg];

    assign wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
    assign rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
    assign fill_next   = fill_reg + QCNT_W'(push) - QCNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= new_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

@@ src/ghn_back.sv @@
// ----------------------------------------------------------------------------
// ghn_back: histogram execution
// bin memory, running maximum, serial divider and result register
// ----------------------------------------------------------------------------
module ghn_back #(
    parameter int NUM_BINS    = ghn_pkg::NUM_BINS_DEF,
    parameter int COUNT_WIDTH = ghn_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    input  ghn_pkg::cmd_t                  cmd,
    output logic                           cmd_take,
    input  logic [ghn_pkg::HEIGHT_W-1:0]   target_height,
    ghn_out_if.source                      result
);
    import ghn_pkg::*;

    localparam int BIN_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int PROD_W = COUNT_WIDTH + HEIGHT_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = '1;

    state_t                 state_reg, state_next;
    kind_t                  kind_reg;
    logic [BIN_W-1:0]       idx_reg;
    logic [BIN_W-1:0]       rd_addr;

    logic [COUNT_WIDTH-1:0] bin_mem [NUM_BINS];
    logic [COUNT_WIDTH-1:0] mem_q;
    logic [NUM_BINS-1:0]    bin_valid_reg;
    logic                   valid_q;
    logic                   mem_we;
    logic                   clear_now;

    logic [COUNT_WIDTH-1:0] fetched;
    logic [COUNT_WIDTH-1:0] bumped;
    logic [COUNT_WIDTH-1:0] max_reg;
    logic [COUNT_WIDTH-1:0] raw_reg;

    logic [PROD_W-1:0]      rem_reg;
    logic [PROD_W-1:0]      div_reg;
    logic [HEIGHT_W-1:0]    quo_reg;
    logic [STEP_W-1:0]      step_reg;
    logic                   trial_ok;
    logic                   last_step;

    assign rd_addr   = cmd.idx[BIN_W-1:0];
    assign fetched   = valid_q ? mem_q : '0;
    assign bumped    = (fetched == COUNT_TOP) ? fetched : fetched + COUNT_WIDTH'(1);
    assign trial_ok  = (rem_reg >= div_reg);
    assign last_step = (step_reg == STEP_W'(HEIGHT_W - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.kind == K_COUNT || cmd.kind == K_READ)
                        state_next = ST_FETCH;
                    else
                        state_next = ST_HOLD;
                end
            end
            ST_FETCH:
            begin
                if (kind_reg == K_READ && max_reg != '0)
                    state_next = ST_DIVIDE;
                else
                    state_next = ST_HOLD;
            end
            ST_DIVIDE:
            begin
                if (last_step)
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (result.ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd_take     = 1'b0;
        mem_we       = 1'b0;
        clear_now    = 1'b0;
        result.valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_take  = cmd_valid;
                clear_now = cmd_valid && (cmd.kind == K_CLEAR);
            end
            ST_FETCH:
            begin
                mem_we = (kind_reg == K_COUNT);
            end
            ST_HOLD:
            begin
                result.valid = 1'b1;
            end
            default:
            begin
                cmd_take = 1'b0;
            end
        endcase
    end

    assign result.scaled_height = quo_reg;
    assign result.raw_count     = raw_reg;
    assign result.max_count     = max_reg;

    // bin storage, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            bin_mem[idx_reg] <= bumped;
        mem_q   <= bin_mem[rd_addr];
        valid_q <= bin_valid_reg[rd_addr];
    end

    // a bin never written since the last clear reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bin_valid_reg <= '0;
        else if (clear_now)
            bin_valid_reg <= '0;
        else if (mem_we)
            bin_valid_reg[idx_reg] <= 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= K_NOP;
            max_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd_take)
                kind_reg <= cmd.kind;
            if (clear_now)
                max_reg <= '0;
            else if (mem_we && bumped > max_reg)
                max_reg <= bumped;
        end
    end

    // read path: multiply, then one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take)
                begin
                    idx_reg <= rd_addr;
                    raw_reg <= '0;
                    quo_reg <= '0;
                end
            end
            ST_FETCH:
            begin
                if (kind_reg == K_READ)
                begin
                    raw_reg  <= fetched;
                    rem_reg  <= PROD_W'(fetched) * PROD_W'(target_height);
                    div_reg  <= PROD_W'(max_reg) << (HEIGHT_W - 1);
                    step_reg <= '0;
                end
            end
            ST_DIVIDE:
            begin
                if (trial_ok)
                    rem_reg <= rem_reg - div_reg;
                quo_reg  <= {quo_reg[HEIGHT_W-2:0], trial_ok};
                div_reg  <= div_reg >> 1;
                step_reg <= step_reg + STEP_W'(1);
            end
            default:
            begin
                raw_reg <= raw_reg;
            end
        endcase
    end

endmodule

@@ src/gray_histogram_normalizer.sv @@
// ----------------------------------------------------------------------------
// gray_histogram_normalizer: 8-bit gray histogram with max-normalized read
// counts pixels into bins and reads bins scaled to a programmable height
// ----------------------------------------------------------------------------
// usage
//   request channel: operation (clear, count pixel, read bin), pixel_value,
//   bin_index; every accepted item gives exactly one item on the result
//   channel: scaled_height, raw_count, max_count
//   cfg_we/cfg_wdata load target_height (reset 400); the user must write it
//   only while idle, which the block itself does not enforce
// back-end sequence; the next item is taken once a result is accepted
//   clear and unused codes: straight to the result hold (ST_HOLD)
//   count: registered bin memory read, then increment and write back
//   read: bin memory read, then product with target_height; unless the
//   maximum is zero, a restoring divider retires one quotient bit per cycle
//   items pass through the front's queue registers ahead of the back end
// reset
//   all bins read as empty at once (per-bin valid flags), no clearing pass
// stall
//   a result waits in its register while the receiver holds ready low;
//   the front keeps taking up to four items into its queue meanwhile
// ----------------------------------------------------------------------------
module gray_histogram_normalizer #(
    parameter int NUM_BINS    = ghn_pkg::NUM_BINS_DEF,
    parameter int COUNT_WIDTH = ghn_pkg::COUNT_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    ghn_in_if.sink                       request,
    ghn_out_if.source                    result,
    input  logic                         cfg_we,
    input  logic [ghn_pkg::HEIGHT_W-1:0] cfg_wdata
);
    import ghn_pkg::*;

    logic [HEIGHT_W-1:0] height_reg;

    // front to back command handoff
    logic cmd_valid;
    cmd_t cmd;
    logic cmd_take;

    // scale register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            height_reg <= HEIGHT_RESET;
        else if (cfg_we)
            height_reg <= cfg_wdata;
    end

    // intake and decode
    ghn_front #(
        .NUM_BINS (NUM_BINS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    // histogram state and arithmetic
    ghn_back #(
        .NUM_BINS    (NUM_BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_take      (cmd_take),
        .target_height (height_reg),
        .result        (result)
    );

    // back end only pops a non-empty queue
    a_take_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> cmd_valid)
        else $error("command taken from empty queue");

    // no bin ever exceeds the running maximum
    a_raw_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.raw_count <= result.max_count))
        else $error("raw count above running maximum");

    // an empty bin always scales to zero
    a_empty_scales_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.raw_count == '0) |-> (result.scaled_height == '0))
        else $error("empty bin gave nonzero height");

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for gray_histogram_normalizer
// drives clear, count, read and unused items with random gaps on the request
// side and random stalls on the result side, predicts every result item in a
// scoreboard that keeps its own copy of the bins and the running maximum, and
// retunes target_height between phases while the block is idle
// ----------------------------------------------------------------------------
module tb;
    import ghn_pkg::*;

    localparam int NB         = NUM_BINS_DEF;
    localparam int CW         = COUNT_WIDTH_DEF;
    localparam int PHASE_ITEMS = 400;
    localparam int TAIL_CYCLES = 24;       // settle time after the last result
    localparam int LONG_HOLD   = 300;      // receiver hold-off, fills the queue
    localparam int CYCLE_LIMIT = 1_000_000;

    // the package names three codes; the fourth one leaves the histogram as it is
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [HEIGHT_W-1:0] scaled;
        logic [CW-1:0]       raw;
        logic [CW-1:0]       peak;
    } hist_result_t;

    // ------------------------------------------------------------------------
    // scoreboard: predicts one result item per request item and checks them
    // in order
    // ------------------------------------------------------------------------
    class histogram_scoreboard;
        logic [CW-1:0]       bin_count [NB];
        logic [CW-1:0]       largest;
        logic [HEIGHT_W-1:0] height;
        hist_result_t        expected_q [$];
        int                  failures;

        function new();
            foreach (bin_count[b])
                bin_count[b] = '0;
            largest  = '0;
            height   = HEIGHT_RESET;
            failures = 0;
        endfunction

        // an item was taken by the block: update the histogram, queue result
        function void note_request(logic [OP_W-1:0] op, logic [PIX_W-1:0] pix,
                                   logic [PIX_W-1:0] idx);
            hist_result_t e;
            longint unsigned product;
            e = '0;
            case (op)
                OP_CLEAR:
                begin
                    foreach (bin_count[b])
                        bin_count[b] = '0;
                    largest = '0;
                end
                OP_COUNT:
                begin
                    if (int'(pix) < NB)
                    begin
                        // saturating count, maximum follows the bin
                        if (bin_count[pix] != '1)
                            bin_count[pix] = bin_count[pix] + CW'(1);
                        if (bin_count[pix] > largest)
                            largest = bin_count[pix];
                    end
                end
                OP_READ:
                begin
                    if (int'(idx) < NB)
                    begin
                        e.raw = bin_count[idx];
                        if (largest != '0)
                        begin
                            product  = longint'(e.raw) * longint'(height);
                            e.scaled = HEIGHT_W'(product / longint'(largest));
                        end
                    end
                end
                default: ;
            endcase
            e.peak = largest;
            expected_q.push_back(e);
        endfunction

        // a result item left the block: compare with the oldest prediction
        function void check_result(logic [HEIGHT_W-1:0] scaled, logic [CW-1:0] raw,
                                   logic [CW-1:0] peak);
            hist_result_t e;
            if (expected_q.size() == 0)
            begin
                $error("result item with nothing outstanding: scaled_height %0d raw_count %0d max_count %0d",
                       scaled, raw, peak);
                failures++;
                return;
            end
            e = expected_q.pop_front();
            if (scaled !== e.scaled)
            begin
                $error("scaled_height: expected %0d, got %0d", e.scaled, scaled);
                failures++;
            end
            if (raw !== e.raw)
            begin
                $error("raw_count: expected %0d, got %0d", e.raw, raw);
                failures++;
            end
            if (peak !== e.peak)
            begin
                $error("max_count: expected %0d, got %0d", e.peak, peak);
                failures++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [HEIGHT_W-1:0] cfg_wdata;

    ghn_in_if                     req_if ();
    ghn_out_if #(.COUNT_WIDTH(CW)) res_if ();

    gray_histogram_normalizer #(
        .NUM_BINS    (NB),
        .COUNT_WIDTH (CW)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (req_if.sink),
        .result    (res_if.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    histogram_scoreboard board = new();

    bit steady;         // set: neither side idles
    bit hold_request;   // set by stimulus, taken by the receiver
    int cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog on a cycle count
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // result side: random stalls, one long hold-off on request, check every
    // accepted result item
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_left;
        stall_left = 0;
        res_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            // values seen here are the ones before this edge
            if (res_if.valid && res_if.ready)
                board.check_result(res_if.scaled_height, res_if.raw_count,
                                   res_if.max_count);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end
            else if (stall_left == 0 && !steady && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                stall_left--;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // offer one item after a random gap and hold it until taken; valid is
    // left high so that back-to-back items need no second assignment
    task automatic send_item(logic [OP_W-1:0] op, logic [PIX_W-1:0] pix,
                             logic [PIX_W-1:0] idx);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.operation   <= op;
        req_if.pixel_value <= pix;
        req_if.bin_index   <= idx;
        do
            @(posedge clk);
        while (!req_if.ready);
        board.note_request(op, pix, idx);
    endtask

    // stop offering, wait for every outstanding result, then let the back
    // end settle
    task automatic drain();
        req_if.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // target_height is only written with the block idle
    task automatic set_height(logic [HEIGHT_W-1:0] h);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= h;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.height = h;
    endtask

    // one phase of random traffic; a few hot gray levels build tall bins so
    // that scaled reads land all over the range
    task automatic random_phase(int n);
        logic [PIX_W-1:0] hot [4];
        logic [OP_W-1:0]  op;
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] idx;
        int r;
        foreach (hot[h])
            hot[h] = PIX_W'($urandom_range(0, 255));
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 199);
            if (r < 3)
                op = OP_CLEAR;
            else if (r < 14)
                op = OP_UNUSED;
            else if (r < 64)
                op = OP_READ;
            else
                op = OP_COUNT;
            pix = ($urandom_range(0, 9) < 4) ? hot[2'($urandom_range(0, 3))]
                                              : PIX_W'($urandom_range(0, 255));
            idx = ($urandom_range(0, 9) < 5) ? hot[2'($urandom_range(0, 3))]
                                              : PIX_W'($urandom_range(0, 255));
            send_item(op, pix, idx);
        end
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        req_if.valid       <= 1'b0;
        req_if.operation   <= OP_CLEAR;
        req_if.pixel_value <= '0;
        req_if.bin_index   <= '0;
        steady       = 1'b0;
        hold_request = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset height
        send_item(OP_READ,   8'h00, 8'h00);    // empty histogram reads as zero
        send_item(OP_UNUSED, 8'h00, 8'h00);
        send_item(OP_COUNT,  8'h00, 8'hFF);
        send_item(OP_COUNT,  8'hFF, 8'h00);
        send_item(OP_COUNT,  8'hFF, 8'h00);
        send_item(OP_READ,   8'h00, 8'hFF);    // largest bin maps to full height
        send_item(OP_READ,   8'hFF, 8'h00);    // half height
        send_item(OP_READ,   8'h00, 8'h80);    // unused bin under a nonzero max
        send_item(OP_COUNT,  8'hAA, 8'h55);
        send_item(OP_COUNT,  8'h55, 8'hAA);
        send_item(OP_READ,   8'h55, 8'hAA);
        send_item(OP_UNUSED, 8'hFF, 8'hFF);    // must not touch any bin
        send_item(OP_READ,   8'h00, 8'hFF);
        send_item(OP_CLEAR,  8'hFF, 8'hFF);
        send_item(OP_READ,   8'h00, 8'hFF);    // cleared bin and cleared max
        send_item(OP_COUNT,  8'h07, 8'h00);
        send_item(OP_READ,   8'h00, 8'h07);
        send_item(OP_COUNT,  8'h80, 8'h00);
        send_item(OP_READ,   8'h00, 8'h80);

        // lowest nonzero height; the receiver holds off early so the queue backs up
        set_height(10'd1);
        hold_request = 1'b1;
        random_phase(PHASE_ITEMS);

        // highest height, no idling on either side
        set_height(10'd1023);
        steady = 1'b1;
        random_phase(PHASE_ITEMS);
        steady = 1'b0;

        // random heights
        for (int p = 0; p < 3; p++)
        begin
            set_height(HEIGHT_W'($urandom_range(1, 1023)));
            random_phase(PHASE_ITEMS);
        end

        drain();
        if (board.pending() != 0)
        begin
            $error("%0d result items never arrived", board.pending());
            board.failures++;
        end
        if (board.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
